FILE: hdl/ovs_pkg.sv
// Shared types and constants for the oldest-first victim selector.
`timescale 1ns / 1ps

package ovs_pkg;

    // Store capacity and the widths that follow from it.
    localparam int MAX_ENTRIES = 64;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Fixed field widths.
    localparam int ID_W     = 64;
    localparam int AGE_W    = 64;
    localparam int NEEDED_W = 7;
    localparam int STATUS_W = 2;
    localparam int KEY_W    = AGE_W + ID_W;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_VICTIM   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    // Input word: one stored entry.
    typedef struct packed {
        logic [ID_W-1:0]     entry_id;
        logic [AGE_W-1:0]    entry_age;
        logic                set_last;
        logic [NEEDED_W-1:0] victims_needed;
    } in_word_t;

    // Output word: one selection result.
    typedef struct packed {
        logic [ID_W-1:0]     victim_id;
        logic [STATUS_W-1:0] status;
        logic                run_last;
    } out_word_t;

    // Entry memory write port.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [KEY_W-1:0]  data;
    } mem_wr_t;

    // Entry memory read port.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } mem_rd_t;

    // Result request from the controller to the output register.
    typedef struct packed {
        logic      vld;
        out_word_t word;
    } res_req_t;

endpackage

FILE: hdl/ovs_entry_mem.sv
// Entry store: one write port, one read port with a registered read.
`timescale 1ns / 1ps

module ovs_entry_mem
    import ovs_pkg::*;
(
    input  logic             clk,
    input  mem_wr_t          wr,
    input  mem_rd_t          rd,
    output logic [KEY_W-1:0] rd_data
);

    // Each entry holds {age, id}, so a plain compare orders by age, then id.
    logic [KEY_W-1:0] mem [MAX_ENTRIES];
    logic [KEY_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read port, registered read.
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/ovs_ctrl.sv
// Load and selection control: stores entries and scans the store for each victim.
`timescale 1ns / 1ps

module ovs_ctrl
    import ovs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             entry_valid,
    input  in_word_t         entry_word,
    output logic             entry_stall,
    output mem_wr_t          mem_wr,
    output mem_rd_t          mem_rd,
    input  logic [KEY_W-1:0] rd_data,
    output res_req_t         res_req,
    input  logic             res_free
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_EMIT   = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg;
    logic                ovf_reg;
    logic [NEEDED_W-1:0] needed_reg;
    logic [NEEDED_W-1:0] emit_cnt_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [CNT_W-1:0]    rd_cnt_reg;
    logic                rd_vld_reg;
    logic [ADDR_W-1:0]   rd_idx_reg;
    logic                best_vld_reg;
    logic [KEY_W-1:0]    best_key_reg;
    logic [ADDR_W-1:0]   best_idx_reg;
    logic [MAX_ENTRIES-1:0] taken_reg;

    logic             accept;
    logic             has_room;
    logic [CNT_W-1:0] count_after;
    logic             ovf_now;
    logic             too_few;
    logic             issue;
    logic             scan_done;
    logic             better;
    logic             emit_last;
    logic             run_end;

    // Entries are taken only between runs.
    assign entry_stall = (state_reg != ST_IDLE);
    assign accept      = entry_valid && !entry_stall;

    // Store occupancy after this entry; a full store drops the entry.
    assign has_room    = (count_reg < CNT_W'(MAX_ENTRIES));
    assign count_after = has_room ? (count_reg + CNT_W'(1)) : count_reg;
    assign ovf_now     = ovf_reg || !has_room;
    assign too_few     = (entry_word.victims_needed == '0)
                      || (NEEDED_W'(count_after) < entry_word.victims_needed);

    // Write the arriving entry at the next free slot.
    assign mem_wr.en   = accept && has_room;
    assign mem_wr.addr = count_reg[ADDR_W-1:0];
    assign mem_wr.data = {entry_word.entry_age, entry_word.entry_id};

    // Scan reads every stored slot once per victim. The last write of a set
    // lands before the first scan read, so no forwarding is needed.
    assign issue       = (state_reg == ST_SCAN) && (rd_cnt_reg < count_reg);
    assign mem_rd.en   = issue;
    assign mem_rd.addr = rd_cnt_reg[ADDR_W-1:0];
    assign scan_done   = (state_reg == ST_SCAN) && !issue && !rd_vld_reg;

    // Strict compare keeps the lowest slot among equal keys.
    assign better = rd_vld_reg && !taken_reg[rd_idx_reg]
                 && (!best_vld_reg || (rd_data < best_key_reg));

    assign emit_last = ((emit_cnt_reg + NEEDED_W'(1)) == needed_reg);
    assign run_end   = res_free && (((state_reg == ST_EMIT) && emit_last)
                                  || (state_reg == ST_RESULT));

    // Result request toward the output register.
    always_comb
    begin
        res_req.vld           = (state_reg == ST_EMIT) || (state_reg == ST_RESULT);
        res_req.word.victim_id = '0;
        res_req.word.status   = status_reg;
        res_req.word.run_last = 1'b1;
        if (state_reg == ST_EMIT)
        begin
            res_req.word.victim_id = best_key_reg[ID_W-1:0];
            res_req.word.status    = STATUS_VICTIM;
            res_req.word.run_last  = emit_last;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && entry_word.set_last)
                begin
                    if (ovf_now || too_few)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (res_free)
                begin
                    state_next = emit_last ? ST_IDLE : ST_SCAN;
                end
            end
            ST_RESULT:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            emit_cnt_reg <= '0;
            rd_cnt_reg   <= '0;
            rd_vld_reg   <= 1'b0;
            best_vld_reg <= 1'b0;
            taken_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;

            // Set loading.
            if (accept)
            begin
                count_reg <= count_after;
                ovf_reg   <= entry_word.set_last ? 1'b0 : ovf_now;
            end
            if (run_end)
            begin
                count_reg <= '0;
            end

            // Start of a run.
            if (accept && entry_word.set_last)
            begin
                emit_cnt_reg <= '0;
                taken_reg    <= '0;
                rd_cnt_reg   <= '0;
                best_vld_reg <= 1'b0;
            end

            // Scan of the store.
            if (issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
            end
            if (better)
            begin
                best_vld_reg <= 1'b1;
            end

            // Victim handed over: retire it and, if more are needed, rescan.
            if ((state_reg == ST_EMIT) && res_free)
            begin
                taken_reg[best_idx_reg] <= 1'b1;
                emit_cnt_reg            <= emit_cnt_reg + NEEDED_W'(1);
                rd_cnt_reg              <= '0;
                best_vld_reg            <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept && entry_word.set_last)
        begin
            needed_reg <= entry_word.victims_needed;
            status_reg <= ovf_now ? STATUS_OVERFLOW : STATUS_NONE;
        end
        rd_idx_reg <= rd_cnt_reg[ADDR_W-1:0];
        if (better)
        begin
            best_key_reg <= rd_data;
            best_idx_reg <= rd_idx_reg;
        end
    end

endmodule

FILE: hdl/oldest_first_victim_select.sv
// Top level of the oldest-first victim selector.
//
//   Channel  Direction  Handshake                   Word
//   entry    in         entry_valid / entry_stall   in_word_t  (one stored entry)
//   victim   out        victim_valid / victim_stall out_word_t (one result)
//
// Entries load at one per cycle into the entry memory while no run is in progress.
// On the last entry of a set the block scans the memory once per victim:
// each scan issues one read per stored entry, waits for the registered read
// data, closes the scan and then hands the victim off; the single memory
// read port sets the length of a run.
// A run that selects nothing offers its one result: the control enters its result
// state after the last entry is taken, and the word then passes the output register.
// Reset clears the entry count, overflow flag and control; memory is not cleared.
// victim_stall holds the result in the output register; a finished scan then
// waits in its hand-off state until the register frees.
// entry_stall is high from the last entry of a set until its final result
// moves into the output register.
`timescale 1ns / 1ps

module oldest_first_victim_select
    import ovs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      entry_valid,
    input  in_word_t  entry_word,
    output logic      entry_stall,
    output logic      victim_valid,
    input  logic      victim_stall,
    output out_word_t victim_word
);

    mem_wr_t          mem_wr;
    mem_rd_t          mem_rd;
    logic [KEY_W-1:0] rd_data;
    res_req_t         res_req;
    logic             res_free;

    logic      victim_valid_reg;
    out_word_t victim_word_reg;

    // Entry memory.
    ovs_entry_mem u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd      (mem_rd),
        .rd_data (rd_data)
    );

    // Load and selection control.
    ovs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (entry_valid),
        .entry_word  (entry_word),
        .entry_stall (entry_stall),
        .mem_wr      (mem_wr),
        .mem_rd      (mem_rd),
        .rd_data     (rd_data),
        .res_req     (res_req),
        .res_free    (res_free)
    );

    // Output register takes a new word when empty or being drained.
    assign res_free = !victim_valid_reg || !victim_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            victim_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            victim_valid_reg <= res_req.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_free && res_req.vld)
        begin
            victim_word_reg <= res_req.word;
        end
    end

    assign victim_valid = victim_valid_reg;
    assign victim_word  = victim_word_reg;

endmodule

FILE: hdl/ovs_checker.sv
// Port-level checks for the victim selector and their binding to the top level.
`timescale 1ns / 1ps

module ovs_checker
    import ovs_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      entry_valid,
    input in_word_t  entry_word,
    input logic      entry_stall,
    input logic      victim_valid,
    input logic      victim_stall,
    input out_word_t victim_word
);

    // A stalled result word stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        victim_valid && victim_stall |=> victim_valid && $stable(victim_word))
    else $error("victim word changed while stalled");

    // Only the three defined status codes appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        victim_valid |-> (victim_word.status == STATUS_VICTIM)
                      || (victim_word.status == STATUS_NONE)
                      || (victim_word.status == STATUS_OVERFLOW))
    else $error("undefined status code");

    // A no-selection result is the only result of its run and carries no id.
    assert property (@(posedge clk) disable iff (!rst_n)
        victim_valid && (victim_word.status != STATUS_VICTIM)
            |-> victim_word.run_last && (victim_word.victim_id == '0))
    else $error("no-selection result malformed");

    // While a run still has results to come, no entry is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        victim_valid && !victim_word.run_last |-> entry_stall)
    else $error("entry taken during a selection run");

    // The last entry of a set starts a run that blocks the entry channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid && !entry_stall && entry_word.set_last |=> entry_stall)
    else $error("entry channel open right after last entry");

endmodule

bind oldest_first_victim_select ovs_checker u_ovs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .entry_valid  (entry_valid),
    .entry_word   (entry_word),
    .entry_stall  (entry_stall),
    .victim_valid (victim_valid),
    .victim_stall (victim_stall),
    .victim_word  (victim_word)
);

FILE: tb/tb_oldest_first_victim_select.sv
// Self-checking testbench for the oldest-first victim selector.
`timescale 1ns / 1ps

module tb_oldest_first_victim_select;
    import ovs_pkg::*;

    localparam int PERIOD_NS    = 12;
    localparam int LIMIT_CYCLES = 2_500_000;
    localparam int RANDOM_ITEMS = 370;

    // One row of the directed table. A row is sent reps times; a typed result,
    // when present, replaces the predicted one for the last word of a set.
    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [AGE_W-1:0]    age;
        logic                last;
        logic [NEEDED_W-1:0] needed;
        int                  reps;
        bit                  has_note;
        out_word_t           note;
    } plan_row_t;

    localparam out_word_t NO_NOTE = '0;
    localparam logic [63:0] ALL_ONES = '1;

    localparam int PLAN_ROWS = 17;
    localparam plan_row_t plan [PLAN_ROWS] = '{
        // Single entry sets right after reset, and at both extremes of the keys.
        '{64'h0123_4567_89AB_CDEF, 64'd5, 1'b1, 7'd1, 1, 1'b1,
          '{64'h0123_4567_89AB_CDEF, STATUS_VICTIM, 1'b1}},
        '{ALL_ONES, ALL_ONES, 1'b1, 7'd1, 1, 1'b1, '{ALL_ONES, STATUS_VICTIM, 1'b1}},
        '{64'd0, 64'd0, 1'b1, 7'd1, 1, 1'b1, '{64'd0, STATUS_VICTIM, 1'b1}},
        // Nothing wanted.
        '{64'd5, 64'd5, 1'b1, 7'd0, 1, 1'b1, '{64'd0, STATUS_NONE, 1'b1}},
        // More wanted than stored, including values at and above the capacity.
        '{64'd10, 64'd3, 1'b0, 7'd0, 1, 1'b0, NO_NOTE},
        '{64'd11, 64'd2, 1'b1, 7'd3, 1, 1'b1, '{64'd0, STATUS_NONE, 1'b1}},
        '{64'd12, 64'd1, 1'b1, 7'd64, 1, 1'b1, '{64'd0, STATUS_NONE, 1'b1}},
        '{64'd13, 64'd1, 1'b1, 7'd127, 1, 1'b1, '{64'd0, STATUS_NONE, 1'b1}},
        // Age order with a tie on age broken by the identifier.
        '{64'd9, 64'd7, 1'b0, 7'd0, 1, 1'b0, NO_NOTE},
        '{64'd3, 64'd0, 1'b0, 7'd0, 1, 1'b0, NO_NOTE},
        '{64'd1, ALL_ONES, 1'b0, 7'd0, 1, 1'b0, NO_NOTE},
        '{64'd2, 64'd7, 1'b1, 7'd4, 1, 1'b0, NO_NOTE},
        // Identical age and identifier stored twice.
        '{64'd42, 64'd1, 1'b0, 7'd0, 2, 1'b0, NO_NOTE},
        '{64'd41, 64'd1, 1'b1, 7'd3, 1, 1'b0, NO_NOTE},
        // Store filled, then one more entry overflows it.
        '{64'd77, 64'd8, 1'b0, 7'd0, MAX_ENTRIES, 1'b0, NO_NOTE},
        '{64'd78, 64'd1, 1'b1, 7'd1, 1, 1'b1, '{64'd0, STATUS_OVERFLOW, 1'b1}},
        // A fresh set after the overflow.
        '{64'd6, 64'd6, 1'b1, 7'd1, 1, 1'b1, '{64'd6, STATUS_VICTIM, 1'b1}}
    };

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      entry_valid  = 1'b0;
    in_word_t  entry_word   = '0;
    logic      entry_stall;
    logic      victim_valid;
    logic      victim_stall = 1'b0;
    out_word_t victim_word;

    // Typed result that travels along with the word on the entry channel.
    bit        note_valid = 1'b0;
    out_word_t note_word  = '0;

    // Predictor state: the entries of the current set.
    logic [ID_W-1:0]  held_id  [MAX_ENTRIES];
    logic [AGE_W-1:0] held_age [MAX_ENTRIES];
    int               held_count   = 0;
    bit               held_dropped = 1'b0;
    out_word_t        fresh_results [$];
    out_word_t        pending_victims [$];

    int  fail_count = 0;
    int  items_sent = 0;
    int  stall_left = 0;
    bit  quiet      = 1'b0;

    oldest_first_victim_select i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry_valid  (entry_valid),
        .entry_word   (entry_word),
        .entry_stall  (entry_stall),
        .victim_valid (victim_valid),
        .victim_stall (victim_stall),
        .victim_word  (victim_word)
    );

    always #(PERIOD_NS / 2) clk = ~clk;

    // Idle length: mostly none, some short, a few long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Stores one entry and, on the last word of a set, works out the victims.
    function automatic void predict_victims(input in_word_t w);
        bit        taken [MAX_ENTRIES];
        int        best;
        out_word_t r;
        fresh_results.delete();
        if (held_count < MAX_ENTRIES)
        begin
            held_age[held_count] = w.entry_age;
            held_id[held_count]  = w.entry_id;
            held_count++;
        end
        else
        begin
            held_dropped = 1'b1;
        end
        if (!w.set_last)
            return;
        r          = '0;
        r.run_last = 1'b1;
        if (held_dropped)
        begin
            r.status = STATUS_OVERFLOW;
            fresh_results = {fresh_results, r};
        end
        else if (w.victims_needed == 0 || held_count < w.victims_needed)
        begin
            r.status = STATUS_NONE;
            fresh_results = {fresh_results, r};
        end
        else
        begin
            foreach (taken[i])
                taken[i] = 1'b0;
            // Repeatedly pick the oldest entry not yet taken; the earlier slot
            // wins when age and identifier are both equal.
            for (int k = 0; k < w.victims_needed; k++)
            begin
                best = -1;
                for (int i = 0; i < held_count; i++)
                begin
                    if (!taken[i] && (best < 0 || held_age[i] < held_age[best] ||
                        (held_age[i] == held_age[best] && held_id[i] < held_id[best])))
                        best = i;
                end
                taken[best] = 1'b1;
                r.victim_id = held_id[best];
                r.status    = STATUS_VICTIM;
                r.run_last  = (k + 1 == w.victims_needed);
                fresh_results = {fresh_results, r};
            end
        end
        held_count   = 0;
        held_dropped = 1'b0;
    endfunction

    // Check each taken result word first, then record the entry word taken
    // at the same edge.
    always @(posedge clk)
    begin : track_words
        out_word_t want;
        if (rst_n && victim_valid && !victim_stall)
        begin
            if (pending_victims.size() == 0)
            begin
                $display("%0t: result word with none expected: id=%h status=%0d last=%b",
                         $time, victim_word.victim_id, victim_word.status,
                         victim_word.run_last);
                fail_count++;
            end
            else
            begin
                want = pending_victims.pop_front();
                if (victim_word.victim_id !== want.victim_id ||
                    victim_word.status !== want.status ||
                    victim_word.run_last !== want.run_last)
                begin
                    $display("%0t: expected id=%h st=%0d last=%b, got id=%h st=%0d last=%b",
                             $time, want.victim_id, want.status, want.run_last,
                             victim_word.victim_id, victim_word.status,
                             victim_word.run_last);
                    fail_count++;
                end
            end
        end
        if (rst_n && entry_valid && !entry_stall)
        begin
            predict_victims(entry_word);
            if (entry_word.set_last && note_valid)
                pending_victims = {pending_victims, note_word};
            else
                pending_victims = {pending_victims, fresh_results};
        end
    end

    // Receiver backpressure in random bursts, switched off in quiet stretches.
    always @(posedge clk)
    begin
        if (stall_left == 0 && !quiet)
            stall_left = idle_len();
        if (stall_left > 0)
        begin
            victim_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            victim_stall <= 1'b0;
        end
    end

    // Present one word after a random gap and hold it until it is taken.
    task automatic send_entry(input in_word_t w, input bit has_note, input out_word_t note);
        int gap;
        gap = quiet ? 0 : idle_len();
        if (gap > 0)
        begin
            entry_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        entry_valid <= 1'b1;
        entry_word  <= w;
        note_valid  <= has_note;
        note_word   <= note;
        @(posedge clk);
        while (entry_stall) @(posedge clk);
    endtask

    // Keys: narrow ranges give many ties; the rest random, some extreme.
    function automatic logic [63:0] pick_key(input int style, input int narrow_max);
        case (style)
            0: return 64'($urandom_range(0, narrow_max));
            1: return {$urandom, $urandom};
            default:
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return 64'($urandom_range(0, 3));
                    default: return {$urandom, $urandom};
                endcase
        endcase
    endfunction

    // One set of random entries that asks for the given number of victims.
    task automatic send_random_set(input int set_size, input int wanted);
        in_word_t w;
        int       style;
        style = $urandom_range(0, 2);
        for (int n = 0; n < set_size; n++)
        begin
            w.entry_id       = pick_key(style, 15);
            w.entry_age      = pick_key(style, 7);
            w.set_last       = (n == set_size - 1);
            w.victims_needed = w.set_last ? NEEDED_W'(wanted)
                                          : NEEDED_W'($urandom_range(0, 127));
            send_entry(w, 1'b0, NO_NOTE);
            items_sent++;
        end
    endtask

    // Random sets, mostly small, until the item count reaches the mark.
    task automatic send_random_sets(input int upto);
        int r;
        int set_size;
        int wanted;
        while (items_sent < upto)
        begin
            r = $urandom_range(0, 99);
            set_size = r < 70 ? $urandom_range(1, 8) :
                       r < 90 ? $urandom_range(9, 24) :
                       r < 95 ? MAX_ENTRIES : $urandom_range(MAX_ENTRIES + 1, MAX_ENTRIES + 6);
            r = $urandom_range(0, 99);
            wanted = r < 75 ? $urandom_range(1, set_size < MAX_ENTRIES ? set_size : MAX_ENTRIES) :
                     r < 85 ? 0 :
                     r < 95 ? $urandom_range(set_size + 1, set_size + 4) :
                     $urandom_range(MAX_ENTRIES + 1, 127);
            send_random_set(set_size, wanted);
        end
    endtask

    // Stop sending and wait for every expected result word.
    task automatic wait_drained();
        entry_valid <= 1'b0;
        @(posedge clk);
        while (pending_victims.size() != 0) @(posedge clk);
    endtask

    // Main sequence: reset, directed table, random phases, final verdict.
    initial
    begin : run_test
        in_word_t w;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[r])
        begin
            w = {plan[r].id, plan[r].age, plan[r].last, plan[r].needed};
            repeat (plan[r].reps)
                send_entry(w, plan[r].has_note, plan[r].note);
        end

        // Full store with every entry selected.
        send_random_set(MAX_ENTRIES, MAX_ENTRIES);
        send_random_sets(150);

        // Let the block run dry, then a stretch without any idling.
        wait_drained();
        quiet <= 1'b1;
        send_random_sets(250);
        wait_drained();
        quiet <= 1'b0;

        // Store overflow by more than one entry.
        send_random_set(MAX_ENTRIES + 2, 1);
        send_random_sets(RANDOM_ITEMS);

        wait_drained();
        repeat (4 * MAX_ENTRIES) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #(LIMIT_CYCLES * PERIOD_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: oldest_first_victim_select.f
hdl/ovs_pkg.sv
hdl/ovs_entry_mem.sv
hdl/ovs_ctrl.sv
hdl/oldest_first_victim_select.sv
hdl/ovs_checker.sv
tb/tb_oldest_first_victim_select.sv
